>>> rtl/core/mlfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mlfd_pkg;

   // Header size in bytes (6 to 8); bytes 4 and 5 carry the payload length
   localparam int HEADER_BYTES = 8;
   localparam int BEAT_W       = $clog2(HEADER_BYTES);
   // Room for a header entry plus the payload bytes arriving while it spills
   localparam int QUEUE_DEPTH  = HEADER_BYTES + 1;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 17;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAGIC_WORD      = 2'd0,
      CSR_MAX_FRAME_BYTES = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] magic_word;
      logic [16:0] max_frame_bytes;
   } cfg_type;

   // One queue entry: either a whole header burst or one payload byte (in bytes[0])
   typedef struct packed {
      logic                               is_header;
      logic                               last_flag;  // header: zero length; payload: final byte
      logic [HEADER_BYTES-1:0][7:0]       bytes;
   } entry_type;

endpackage
`default_nettype wire

>>> rtl/core/mlfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mlfd_pkg::cfg_type    cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_rx_byte,
   input  wire logic                 q_full,
   output logic                      q_push,
   output mlfd_pkg::entry_type       q_entry
);

   localparam int HB = mlfd_pkg::HEADER_BYTES;

   logic [7:0]                  win_ff [HB];
   logic [7:0]                  win_in [HB];
   logic [mlfd_pkg::BEAT_W-1:0] count_ff, count_in;
   logic                        in_payload_ff, in_payload_in;
   logic [15:0]                 payload_left_ff, payload_left_in;

   logic                        accept;
   logic [7:0]                  full_win [HB];
   logic [15:0]                 plen;
   logic [16:0]                 frame_len;
   logic                        magic_ok;
   logic                        len_ok;
   logic                        window_full;
   logic                        final_byte;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Window as it stands once the arriving byte is appended
   always_comb begin
      for (int i = 0; i < HB; i++) begin
         full_win[i] = (i == HB - 1) ? req_rx_byte : win_ff[i];
      end
   end

   // Header checks: magic word and total frame length
   assign plen        = {full_win[4], full_win[5]};
   assign frame_len   = {1'b0, plen} + 17'(HB);
   assign magic_ok    = (full_win[0] == (cfg.magic_word[15:8] & mlfd_pkg::BYTE_MASK)) &&
                        (full_win[1] == (cfg.magic_word[7:0] & mlfd_pkg::BYTE_MASK));
   assign len_ok      = (frame_len <= cfg.max_frame_bytes);
   assign window_full = (count_ff == mlfd_pkg::BEAT_W'(HB - 1));
   assign final_byte  = (payload_left_ff <= 16'd1);

   // Classify the byte and build the queue entry
   always_comb begin
      win_in          = win_ff;
      count_in        = count_ff;
      in_payload_in   = in_payload_ff;
      payload_left_in = payload_left_ff;
      q_push          = 1'b0;
      q_entry         = '0;
      if (accept) begin
         if (in_payload_ff) begin
            q_push            = 1'b1;
            q_entry.is_header = 1'b0;
            q_entry.last_flag = final_byte;
            q_entry.bytes[0]  = req_rx_byte;
            if (final_byte) begin
               in_payload_in   = 1'b0;
               payload_left_in = 16'd0;
            end else begin
               payload_left_in = payload_left_ff - 16'd1;
            end
         end else if (!window_full) begin
            win_in[count_ff] = req_rx_byte;
            count_in         = count_ff + mlfd_pkg::BEAT_W'(1);
         end else if (magic_ok && len_ok) begin
            q_push            = 1'b1;
            q_entry.is_header = 1'b1;
            q_entry.last_flag = (plen == 16'd0);
            for (int i = 0; i < HB; i++) begin
               q_entry.bytes[i] = full_win[i];
            end
            count_in = '0;
            if (plen != 16'd0) begin
               in_payload_in   = 1'b1;
               payload_left_in = plen;
            end
         end else begin
            // drop the oldest byte, keep hunting
            for (int i = 0; i < HB - 1; i++) begin
               win_in[i] = full_win[i + 1];
            end
         end
      end
   end

   // Window bytes need no reset
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         in_payload_ff   <= 1'b0;
         payload_left_ff <= 16'd0;
      end else begin
         count_ff        <= count_in;
         in_payload_ff   <= in_payload_in;
         payload_left_ff <= payload_left_in;
      end
   end

   // A header is emitted only from a full window
   a_push_header_full: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_entry.is_header) |-> (window_full && !in_payload_ff))
      else $error("header pushed from partial window");

   // While passing payload the window stays empty
   a_payload_empty_win: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (count_ff == '0))
      else $error("window not empty during payload");

endmodule
`default_nettype wire

>>> rtl/core/mlfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire mlfd_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output mlfd_pkg::entry_type      head_entry
);

   localparam int DEPTH = mlfd_pkg::QUEUE_DEPTH;

   mlfd_pkg::entry_type               slot_ff [DEPTH];
   logic [mlfd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mlfd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mlfd_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == mlfd_pkg::QCNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mlfd_pkg::QPTR_W'(DEPTH - 1)) ? '0
                     : wr_ptr_ff + mlfd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mlfd_pkg::QPTR_W'(DEPTH - 1)) ? '0
                     : rd_ptr_ff + mlfd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mlfd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mlfd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue underflow");

endmodule
`default_nettype wire

>>> rtl/core/mlfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire mlfd_pkg::entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_first_of_frame,
   output logic                     rsp_last_of_frame,
   output logic                     rsp_last_of_run
);

   localparam int HB = mlfd_pkg::HEADER_BYTES;

   logic [mlfd_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        first_ff, first_in;
   logic                        last_frame_ff, last_frame_in;
   logic                        last_run_ff, last_run_in;

   logic                        load;
   logic                        tail_beat;
   logic                        last_beat;

   assign load      = q_valid && (!valid_ff || rsp_ready);
   assign tail_beat = (beat_ff == mlfd_pkg::BEAT_W'(HB - 1));
   assign last_beat = !q_entry.is_header || tail_beat;
   assign q_pop     = load && last_beat;

   // Walk through the head entry one result per cycle while rsp_ready does not hold the output
   always_comb begin
      beat_in       = beat_ff;
      valid_in      = valid_ff && !rsp_ready;
      byte_in       = byte_ff;
      first_in      = first_ff;
      last_frame_in = last_frame_ff;
      last_run_in   = last_run_ff;
      if (load) begin
         valid_in    = 1'b1;
         beat_in     = last_beat ? '0 : beat_ff + mlfd_pkg::BEAT_W'(1);
         last_run_in = last_beat;
         if (q_entry.is_header) begin
            byte_in       = q_entry.bytes[beat_ff];
            first_in      = (beat_ff == '0);
            last_frame_in = tail_beat && q_entry.last_flag;
         end else begin
            byte_in       = q_entry.bytes[0];
            first_in      = 1'b0;
            last_frame_in = q_entry.last_flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      first_ff      <= first_in;
      last_frame_ff <= last_frame_in;
      last_run_ff   <= last_run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_byte     = byte_ff;
   assign rsp_first_of_frame = first_ff;
   assign rsp_last_of_frame  = last_frame_ff;
   assign rsp_last_of_run    = last_run_ff;

   // Mid-burst, the head entry must be a header still waiting
   a_midburst_header: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != '0) |-> (q_valid && q_entry.is_header))
      else $error("burst counter running without header entry");

endmodule
`default_nettype wire

>>> rtl/core/magic_length_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Magic-word / length-prefixed frame deframer. Received bytes enter one per cycle on
// the req_ channel while req_ready is high. The front stage hunts for a header (magic
// word in bytes 0-1, big-endian payload length in bytes 4-5) and pushes each accepted
// header, and each payload byte, into a queue of HEADER_BYTES + 1 entries. The back
// stage drains the queue through a registered output: one result per cycle while
// rsp_ready allows, so a header burst gives HEADER_BYTES results on rsp_ and a payload
// byte one. The entry caused by a byte is written into the queue, then loaded into
// the output register, before its first result is valid on rsp_. Sustained input
// rate is one byte per cycle: the queue holds a header entry plus the payload bytes
// that arrive during its burst, so with rsp_ready held high req_ready never drops; it
// drops only when the output is held off long enough to fill the queue. Configuration
// (csr_) is always ready and should be written only while no frame is in flight.
module magic_length_frame_deframer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mlfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mlfd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_frame_byte,
   output logic                                    rsp_first_of_frame,
   output logic                                    rsp_last_of_frame,
   output logic                                    rsp_last_of_run
);

   mlfd_pkg::cfg_type   cfg_ff, cfg_in;
   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_valid;
   mlfd_pkg::entry_type push_entry;
   mlfd_pkg::entry_type head_entry;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mlfd_pkg::CSR_MAGIC_WORD:      cfg_in.magic_word      = csr_wdata[15:0];
            mlfd_pkg::CSR_MAX_FRAME_BYTES: cfg_in.max_frame_bytes = csr_wdata[16:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word      <= 16'd0;
         cfg_ff.max_frame_bytes <= 17'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   mlfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   mlfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_entry            (head_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
`default_nettype wire
